// ===== sv/swmq_pkg.sv =====
// Shared types and constants for the sliding window minimum queue.
// No dependencies; every other file but swmq_ram imports this package.
`default_nettype none

package swmq_pkg;

  localparam int unsigned QueueDepth = 1024;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned CostW      = 56;
  localparam int unsigned IdW        = 16;

  // reported when nothing is held
  localparam logic signed [CostW-1:0] EmptyCost = 56'sd1000000000000000;

  typedef struct packed {
    logic                    restart;
    logic signed [CostW-1:0] entry_cost;
    logic [IdW-1:0]          entry_id;
    logic [IdW-1:0]          window_low;
  } in_item_t;

  typedef struct packed {
    logic signed [CostW-1:0] min_cost;
    logic [IdW-1:0]          min_id;
    logic                    queue_empty;
    logic                    overflow;
  } out_item_t;

  // one front stack entry: the entry and the running minimum of it and all below it
  typedef struct packed {
    logic signed [CostW-1:0] cost;
    logic [IdW-1:0]          id;
    logic signed [CostW-1:0] run_min;
    logic [IdW-1:0]          run_id;
  } front_word_t;

  typedef struct packed {
    logic signed [CostW-1:0] run_min;
    logic [IdW-1:0]          run_id;
  } back_word_t;

  typedef struct packed {
    logic load_in;
    logic push;
    logic xfer_rd;
    logic xfer_wr;
    logic pop;
    logic load_back_top;
    logic load_out;
  } swmq_cmd_t;

  typedef struct packed {
    logic front_empty;
    logic back_empty;
    logic front_last;
    logic back_last;
    logic have_min;
    logic min_below;
    logic out_free;
  } swmq_status_t;

endpackage

`default_nettype wire

// ===== sv/swmq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
`default_nettype none

module swmq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/swmq_ctrl.sv =====
// Sequencer for the minimum queue: push, evict loop, stack transfer, result.
// Depends on swmq_pkg for command and status types.
`default_nettype none

module swmq_ctrl
  import swmq_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_stall_o,
  input  swmq_status_t status_i,
  output swmq_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StPush, StCheck, StXferRd, StXferWr, StPopRd, StPopLd, StDone
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StPush;
        end
      end
      StPush: begin
        cmd_o.push = 1'b1;
        state_d    = StCheck;
      end
      StCheck: begin
        if (!status_i.have_min || !status_i.min_below) begin
          state_d = StDone;
        end else if (status_i.back_empty) begin
          state_d = StXferRd;
        end else begin
          state_d = StPopRd;
        end
      end
      StXferRd: begin
        cmd_o.xfer_rd = 1'b1;
        state_d       = StXferWr;
      end
      StXferWr: begin
        cmd_o.xfer_wr = 1'b1;
        state_d       = status_i.front_last ? StPopRd : StXferRd;
      end
      StPopRd: begin
        // drop the back top and fetch the entry below it
        cmd_o.pop = 1'b1;
        state_d   = status_i.back_last ? StCheck : StPopLd;
      end
      StPopLd: begin
        cmd_o.load_back_top = 1'b1;
        state_d             = StCheck;
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

`default_nettype wire

// ===== sv/swmq_datapath.sv =====
// Datapath: stack memories, counts, top-of-stack minima, output register.
// Depends on swmq_pkg and swmq_ram.
`default_nettype none

module swmq_datapath
  import swmq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  in_item_t     in_data_i,
  input  swmq_cmd_t    cmd_i,
  output swmq_status_t status_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_item_t    out_data_o
);

  in_item_t                in_q;
  logic [CntW-1:0]         fcnt_q, bcnt_q;
  logic signed [CostW-1:0] ftop_min_q, btop_min_q;
  logic [IdW-1:0]          ftop_id_q, btop_id_q;
  logic                    ovf_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic                    full;
  logic signed [CostW-1:0] push_min;
  logic [IdW-1:0]          push_id;
  front_word_t             front_wdata, front_rdata;
  back_word_t              back_wdata, back_rdata;
  logic                    front_we;
  logic                    hf, hb, sel_back;
  logic signed [CostW-1:0] cur_cost;
  logic [IdW-1:0]          cur_id;
  out_item_t               result;

  assign full = ({1'b0, fcnt_q} + {1'b0, bcnt_q}) >= (CntW + 1)'(QueueDepth);

  always_comb begin
    push_min = in_q.entry_cost;
    push_id  = in_q.entry_id;
    if (fcnt_q != '0 && ftop_min_q < in_q.entry_cost) begin
      push_min = ftop_min_q;
      push_id  = ftop_id_q;
    end
  end

  assign front_we    = cmd_i.push && !full;
  assign front_wdata = '{cost: in_q.entry_cost, id: in_q.entry_id,
                         run_min: push_min, run_id: push_id};

  // moving an entry across: back stack ties keep the older (lower) entry
  always_comb begin
    back_wdata.run_min = front_rdata.cost;
    back_wdata.run_id  = front_rdata.id;
    if (bcnt_q != '0 && btop_min_q < front_rdata.cost) begin
      back_wdata.run_min = btop_min_q;
      back_wdata.run_id  = btop_id_q;
    end
  end

  swmq_ram #(
    .Width($bits(front_word_t)),
    .Depth(QueueDepth)
  ) u_front_ram (
    .clk_i  (clk_i),
    .we_i   (front_we),
    .waddr_i(fcnt_q[AddrW-1:0]),
    .wdata_i(front_wdata),
    .re_i   (cmd_i.xfer_rd),
    .raddr_i(AddrW'(fcnt_q - CntW'(1))),
    .rdata_o(front_rdata)
  );

  swmq_ram #(
    .Width($bits(back_word_t)),
    .Depth(QueueDepth)
  ) u_back_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.xfer_wr),
    .waddr_i(bcnt_q[AddrW-1:0]),
    .wdata_i(back_wdata),
    .re_i   (cmd_i.pop),
    .raddr_i(AddrW'(bcnt_q - CntW'(2))),
    .rdata_o(back_rdata)
  );

  // current minimum: front wins ties
  assign hf       = (fcnt_q != '0);
  assign hb       = (bcnt_q != '0);
  assign sel_back = hb && (!hf || ftop_min_q > btop_min_q);
  assign cur_cost = sel_back ? btop_min_q : ftop_min_q;
  assign cur_id   = sel_back ? btop_id_q : ftop_id_q;

  always_comb begin
    if (hf || hb) begin
      result = '{min_cost: cur_cost, min_id: cur_id, queue_empty: 1'b0, overflow: ovf_q};
    end else begin
      result = '{min_cost: EmptyCost, min_id: '0, queue_empty: 1'b1, overflow: ovf_q};
    end
  end

  assign status_o = '{
    front_empty: !hf,
    back_empty:  !hb,
    front_last:  (fcnt_q == CntW'(1)),
    back_last:   (bcnt_q == CntW'(1)),
    have_min:    hf || hb,
    min_below:   (cur_id < in_q.window_low),
    out_free:    !out_valid_q || !out_stall_i
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_in && in_data_i.restart) begin
        fcnt_q <= '0;
        bcnt_q <= '0;
      end
      if (front_we) begin
        fcnt_q <= fcnt_q + CntW'(1);
      end
      if (cmd_i.xfer_wr) begin
        fcnt_q <= fcnt_q - CntW'(1);
        bcnt_q <= bcnt_q + CntW'(1);
      end
      if (cmd_i.pop) begin
        bcnt_q <= bcnt_q - CntW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q  <= in_data_i;
      ovf_q <= 1'b0;
    end
    if (cmd_i.push) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        ftop_min_q <= push_min;
        ftop_id_q  <= push_id;
      end
    end
    if (cmd_i.xfer_wr) begin
      btop_min_q <= back_wdata.run_min;
      btop_id_q  <= back_wdata.run_id;
    end
    if (cmd_i.load_back_top) begin
      btop_min_q <= back_rdata.run_min;
      btop_id_q  <= back_rdata.run_id;
    end
    if (cmd_i.load_out) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/sliding_window_min_queue_unit.sv =====
// Sliding window minimum queue, two stacks in RAM with running minima.
// With no eviction an input passes the push, check and done states; the result is loaded
// from done once the output is free. One item in flight, taken while a result waits.
// An eviction passes pop-read and pop-load (pop-read alone if it empties the back stack);
// a pop on an empty back stack first moves each front entry across: RAM read, then write.
// Reset clears stack counts and handshake state; the RAMs need no clearing.
`default_nettype none

module sliding_window_min_queue_unit
  import swmq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);

  swmq_cmd_t    cmd;
  swmq_status_t status;

  swmq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  swmq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== test/sliding_window_min_queue_unit_tb.sv =====
// Testbench for sliding_window_min_queue_unit: directed table plus sliding-window,
// queue-fill and noise traffic, checked against a two-stack minimum queue predictor.
// Depends on swmq_pkg and the unit; self-checking, no files or arguments.
`timescale 1ns / 1ps

module sliding_window_min_queue_unit_tb;
  import swmq_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef enum int unsigned {
    CostFull,
    CostTiny,
    CostSmallSigned,
    CostEdge
  } cost_kind_e;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  sliding_window_min_queue_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // predictor state: front stack takes pushes, back stack serves pops
  logic signed [CostW-1:0] fr_cost   [QueueDepth];
  logic [IdW-1:0]          fr_id     [QueueDepth];
  logic signed [CostW-1:0] fr_min    [QueueDepth];
  logic [IdW-1:0]          fr_min_id [QueueDepth];
  logic signed [CostW-1:0] bk_min    [QueueDepth];
  logic [IdW-1:0]          bk_min_id [QueueDepth];
  int unsigned             fr_cnt;
  int unsigned             bk_cnt;

  out_item_t   expected_min_q[$];
  dir_row_t    dir_rows[$];
  int unsigned errors;
  int unsigned burst_left;
  int unsigned cycles;
  int unsigned stall_mode;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic predict_window_min(input in_item_t it, output out_item_t res);
    logic signed [CostW-1:0] m;
    logic signed [CostW-1:0] c;
    logic [IdW-1:0]          mid;
    bit                      have;
    int unsigned             t;
    res = '0;
    if (it.restart) begin
      fr_cnt = 0;
      bk_cnt = 0;
    end
    if (fr_cnt + bk_cnt >= QueueDepth) begin
      res.overflow = 1'b1;
    end else begin
      m = it.entry_cost;
      mid = it.entry_id;
      if (fr_cnt > 0 && fr_min[fr_cnt-1] < m) begin
        m = fr_min[fr_cnt-1];
        mid = fr_min_id[fr_cnt-1];
      end
      fr_cost[fr_cnt] = it.entry_cost;
      fr_id[fr_cnt] = it.entry_id;
      fr_min[fr_cnt] = m;
      fr_min_id[fr_cnt] = mid;
      fr_cnt++;
    end
    while (1'b1) begin
      have = (fr_cnt > 0) || (bk_cnt > 0);
      // front wins ties against back
      if (fr_cnt > 0 && (bk_cnt == 0 || fr_min[fr_cnt-1] <= bk_min[bk_cnt-1])) begin
        m = fr_min[fr_cnt-1];
        mid = fr_min_id[fr_cnt-1];
      end else if (bk_cnt > 0) begin
        m = bk_min[bk_cnt-1];
        mid = bk_min_id[bk_cnt-1];
      end
      if (!have || mid >= it.window_low) break;
      if (bk_cnt == 0) begin
        // move the whole front stack over, newest first
        while (fr_cnt > 0) begin
          t = fr_cnt - 1;
          c = fr_cost[t];
          m = c;
          mid = fr_id[t];
          if (bk_cnt > 0 && bk_min[bk_cnt-1] < c) begin
            m = bk_min[bk_cnt-1];
            mid = bk_min_id[bk_cnt-1];
          end
          bk_min[bk_cnt] = m;
          bk_min_id[bk_cnt] = mid;
          bk_cnt++;
          fr_cnt = t;
        end
      end
      bk_cnt--;
    end
    if (have) begin
      res.min_cost = m;
      res.min_id = mid;
    end else begin
      res.min_cost = EmptyCost;
      res.min_id = '0;
      res.queue_empty = 1'b1;
    end
  endtask

  function automatic logic signed [CostW-1:0] rand_cost(input cost_kind_e kind);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case (kind)
      CostFull: rand_cost = r[CostW-1:0];
      CostTiny: rand_cost = {{(CostW-3){1'b0}}, r[2:0]};
      CostSmallSigned: rand_cost = {{(CostW-3){r[2]}}, r[2:0]};
      default: begin
        case (r[5:4])
          2'd0: rand_cost = {1'b0, {(CostW-1){1'b1}}};
          2'd1: rand_cost = {1'b1, {(CostW-1){1'b0}}};
          2'd2: rand_cost = '0;
          default: rand_cost = '1;
        endcase
      end
    endcase
  endfunction

  function automatic dir_row_t mk_row(bit rs, logic signed [CostW-1:0] c,
                                      logic [IdW-1:0] id, logic [IdW-1:0] lo,
                                      bit typed, logic signed [CostW-1:0] wc,
                                      logic [IdW-1:0] wid, bit wempty);
    dir_row_t r;
    r.item.restart = rs;
    r.item.entry_cost = c;
    r.item.entry_id = id;
    r.item.window_low = lo;
    r.typed = typed;
    r.want.min_cost = wc;
    r.want.min_id = wid;
    r.want.queue_empty = wempty;
    r.want.overflow = 1'b0;
    return r;
  endfunction

  // sender: bursts of random length, random gaps, now and then a long unbroken run
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t   got;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_window_min(it, got);
    expected_min_q.insert(expected_min_q.size(), typed ? want : got);
  endtask

  task automatic field_check(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // receiver stall pattern in a randomly chosen mode; also the run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycles % 5 < 2);
    endcase
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_min_q.size() == 0) begin
        $display("%0t unexpected result transfer: expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want_r = expected_min_q.pop_front();
        field_check("min_cost", want_r.min_cost, out_data.min_cost);
        field_check("min_id", want_r.min_id, out_data.min_id);
        field_check("queue_empty", want_r.queue_empty, out_data.queue_empty);
        field_check("overflow", want_r.overflow, out_data.overflow);
      end
    end
  end

  initial begin
    logic signed [CostW-1:0] c_max;
    logic signed [CostW-1:0] c_min;
    in_item_t                it;
    cost_kind_e              kind;
    int                      id;
    int                      width;
    int                      len;
    int                      n;
    int                      k;

    c_max = {1'b0, {(CostW-1){1'b1}}};
    c_min = {1'b1, {(CostW-1){1'b0}}};
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    rst_n = 1'b0;
    errors = 0;
    burst_left = 0;
    cycles = 0;
    stall_mode = 0;
    fr_cnt = 0;
    bk_cnt = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: plain pushes, ties, stack moves, extremes, empty queue
    dir_rows = {dir_rows, mk_row(1, 5, 1, 0, 1, 5, 1, 0)};
    dir_rows = {dir_rows, mk_row(0, 5, 2, 0, 0, 0, 0, 0)};  // equal cost, newest front wins
    dir_rows = {dir_rows, mk_row(0, 3, 3, 2, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(0, 9, 4, 4, 0, 0, 0, 0)};  // pop with empty back stack
    dir_rows = {dir_rows, mk_row(1, 4, 30, 0, 1, 4, 30, 0)};
    dir_rows = {dir_rows, mk_row(0, 7, 31, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(0, 7, 32, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(0, 9, 33, 31, 0, 0, 0, 0)}; // back tie, oldest wins
    dir_rows = {dir_rows, mk_row(0, 7, 34, 31, 0, 0, 0, 0)}; // front beats back on tie
    dir_rows = {dir_rows, mk_row(1, c_max, 16'hFFFF, 0, 1, c_max, 16'hFFFF, 0)};
    dir_rows = {dir_rows, mk_row(0, c_min, 0, 0, 1, c_min, 0, 0)};
    dir_rows = {dir_rows, mk_row(0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(1, 123, 0, 1, 1, EmptyCost, 0, 1)};
    dir_rows = {dir_rows, mk_row(0, EmptyCost, 5, 0, 1, EmptyCost, 5, 0)};
    dir_rows = {dir_rows, mk_row(1, -1, 16'hFFFF, 16'hFFFF, 1, -1, 16'hFFFF, 0)};
    dir_rows = {dir_rows, mk_row(0, -1, 16'hFFFE, 16'hFFFF, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(1, c_min, 16'h8000, 16'h7FFF, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk_row(0, c_max, 16'h7FFF, 16'h8001, 0, 0, 0, 0)};
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // sliding windows: rising ids, window bound trailing the newest id, now and then just past it
    n = 0;
    while (n < 520) begin
      id = $urandom_range(0, 50000);
      width = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 1500) : $urandom_range(1, 48);
      kind = cost_kind_e'($urandom_range(0, 3));
      len = $urandom_range(8, 120);
      for (k = 0; k < len && id < 65500; k++) begin
        it.restart = (k == 0) || ($urandom_range(0, 99) == 0);
        it.entry_cost = rand_cost(kind);
        it.entry_id = id[IdW-1:0];
        if ($urandom_range(0, 29) == 0) it.window_low = IdW'(id + 1);
        else it.window_low = (id > width) ? IdW'(id - width) : '0;
        send_item(it, 1'b0, '0);
        id += $urandom_range(1, 3);
        n++;
      end
    end

    // fill to capacity, push past it, then evict across a full stack move
    for (k = 0; k < 1040; k++) begin
      it.restart = (k == 0);
      it.entry_cost = rand_cost(cost_kind_e'($urandom_range(0, 3)));
      it.entry_id = IdW'(k);
      if (k < 1030) it.window_low = '0;
      else if (k == 1030) it.window_low = 16'd512;
      else it.window_low = IdW'(k - 300);
      send_item(it, 1'b0, '0);
    end

    // noise: unordered ids, arbitrary bounds
    for (k = 0; k < 200; k++) begin
      it.restart = ($urandom_range(0, 15) == 0);
      it.entry_cost = rand_cost(cost_kind_e'($urandom_range(0, 3)));
      it.entry_id = IdW'($urandom);
      if ($urandom_range(0, 1) == 0) it.window_low = IdW'($urandom);
      else it.window_low = IdW'($urandom_range(0, it.entry_id));
      send_item(it, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (expected_min_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0 && expected_min_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
